@@ src/vrp_pkg.sv @@
`timescale 1ns / 1ps

package vrp_pkg;

  // Vertex store
  localparam int NUM_VERTICES = 8;
  localparam int VIDX_W       = 3;

  // Field widths
  localparam int COORD_W  = 24;
  localparam int TRIG_W   = 16;
  localparam int VIEW_W   = 10;
  localparam int HALF_W   = 15;
  localparam int SCREEN_W = 16;
  localparam int CFG_W    = 24;
  localparam int CFG_AW   = 3;

  // Shared multiplier: one coordinate or offset times one factor
  localparam int MUL_A_W = COORD_W + 1;
  localparam int MUL_B_W = TRIG_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 1;

  // Rotation rounding, Q2.14 factors
  localparam int ANGLE_FRAC_BITS = 14;
  localparam int RND_W           = ACC_W - ANGLE_FRAC_BITS;
  localparam int SUM_W           = RND_W + 1;

  // Projection divider: numerator magnitude below 2^39, divisor a positive z
  localparam int DIV_N_W   = 39;
  localparam int DIV_D_W   = COORD_W - 1;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_COS         = 3'd0;
  localparam logic [CFG_AW-1:0] REG_SIN         = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CENTRE_X    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_CENTRE_Y    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CENTRE_Z    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_VIEW        = 3'd5;
  localparam logic [CFG_AW-1:0] REG_HALF_WIDTH  = 3'd6;
  localparam logic [CFG_AW-1:0] REG_HALF_HEIGHT = 3'd7;

  // Register reset values
  localparam logic signed [TRIG_W-1:0]  COS_RST  = 16'sd16362;
  localparam logic signed [TRIG_W-1:0]  SIN_RST  = 16'sd858;
  localparam logic signed [COORD_W-1:0] CX_RST   = 24'sd0;
  localparam logic signed [COORD_W-1:0] CY_RST   = 24'sd0;
  localparam logic signed [COORD_W-1:0] CZ_RST   = 24'sd38400;
  localparam logic [VIEW_W-1:0]         VIEW_RST = 10'd64;
  localparam logic [HALF_W-1:0]         HW_RST   = 15'd112;
  localparam logic [HALF_W-1:0]         HH_RST   = 15'd54;

  // Request and axis codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_ROTATE = 1'b1;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_R1A,
    ST_R1B,
    ST_R1W,
    ST_R2A,
    ST_R2B,
    ST_R2W,
    ST_ZCHK,
    ST_PA,
    ST_PB,
    ST_PS,
    ST_PW,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [SCREEN_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ src/vrp_div.sv @@
`timescale 1ns / 1ps

module vrp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  vrp_pkg::div_req_t div_req,
  output vrp_pkg::div_rsp_t div_rsp
);
  import vrp_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_D_W-1:0]   rem_r;
  logic [DIV_D_W-1:0]   dv_r;
  logic [DIV_N_W-1:0]   dd_r;
  logic [SCREEN_W-1:0]  q_r;

  logic [DIV_D_W:0]   shifted;
  logic [DIV_D_W+1:0] diff;
  logic               qbit;
  logic [DIV_D_W-1:0] rem_nxt;

  // One restoring step: shift in the next numerator bit, try the divisor
  always_comb begin
    shifted = {rem_r, dd_r[DIV_N_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dv_r};
    qbit    = ~diff[DIV_D_W+1];
    rem_nxt = qbit ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (div_req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_N_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Keep only the low quotient bits: the screen result wraps anyway
  always_ff @(posedge clk) begin
    if (div_req.start) begin
      rem_r <= '0;
      dv_r  <= div_req.divisor;
      dd_r  <= div_req.dividend;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dd_r  <= {dd_r[DIV_N_W-2:0], 1'b0};
      q_r   <= {q_r[SCREEN_W-2:0], qbit};
    end
  end

  assign div_rsp.done = done_r;
  assign div_rsp.quot = q_r;

endmodule

@@ src/vertex_rotate_project.sv @@
`timescale 1ns / 1ps

// Eight-vertex 3D rotate and perspective project engine.
//
// Input channel: an item is taken on a rising edge with start high and busy
// low. A load item (in_req_type = load) writes one vertex in that same edge
// and busy never rises. A rotate item turns every vertex about the centre
// register around in_axis (no turn for axis three) by the cos/sin registers
// (sine negated when in_direction is set), then projects each to the screen.
// Result channel: one beat per vertex, in vertex order, each held for exactly
// one cycle with out_valid high; out_last_point marks the eighth beat. The
// receiver cannot stall, so no beat is ever held back.
// Sequence: per vertex a fetch, two rotation passes of two multiplies and a
// rounded write-back each, a z check, then per screen coordinate two
// multiplies, a divider launch, the 39-step restoring division and an emit.
// A rotate item keeps busy high until its last vertex is emitted, so the next
// item waits for it. A vertex behind the viewer skips the divisions.
// Configuration: cfg_we writes register cfg_addr on the rising edge; write
// only while busy is low and no beat is pending.
// Reset (synchronous, rst_n low): vertices clear to zero, registers take
// their defaults, the sequencer idles and no beat is shown.

module vertex_rotate_project (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_req_type,
  input  logic [vrp_pkg::VIDX_W-1:0]     in_vertex_sel,
  input  logic [vrp_pkg::COORD_W-1:0]    in_coord_x,
  input  logic [vrp_pkg::COORD_W-1:0]    in_coord_y,
  input  logic [vrp_pkg::COORD_W-1:0]    in_coord_z,
  input  logic [1:0]                     in_axis,
  input  logic                           in_direction,
  output logic                           out_valid,
  output logic [vrp_pkg::VIDX_W-1:0]     out_point_index,
  output logic [vrp_pkg::SCREEN_W-1:0]   out_screen_x,
  output logic [vrp_pkg::SCREEN_W-1:0]   out_screen_y,
  output logic                           out_behind_view,
  output logic                           out_last_point,
  input  logic                           cfg_we,
  input  logic [vrp_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [vrp_pkg::CFG_W-1:0]      cfg_wdata
);
  import vrp_pkg::*;

  // Configuration registers
  logic signed [TRIG_W-1:0]  cos_r, sin_r;
  logic signed [COORD_W-1:0] cx_r, cy_r, cz_r;
  logic [VIEW_W-1:0]         vd_r;
  logic [HALF_W-1:0]         hw_r, hh_r;

  // Vertex store, read at the vertex in work
  logic signed [COORD_W-1:0] vx_mem [NUM_VERTICES];
  logic signed [COORD_W-1:0] vy_mem [NUM_VERTICES];
  logic signed [COORD_W-1:0] vz_mem [NUM_VERTICES];

  state_t state_r, state_nxt;

  logic [VIDX_W-1:0]         idx_r;
  logic [1:0]                axis_r;
  logic signed [MUL_B_W-1:0] s_r, ns_r;
  logic signed [MUL_A_W-1:0] ta_r, tb_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      sel_y_r;
  logic                      neg_r;
  logic                      behind_r;
  logic [SCREEN_W-1:0]       sx_r, sy_r;

  logic                      out_valid_r;
  logic [VIDX_W-1:0]         out_idx_r;
  logic [SCREEN_W-1:0]       out_sx_r, out_sy_r;
  logic                      out_behind_r, out_last_r;

  logic signed [COORD_W-1:0] vx_rd, vy_rd, vz_rd;
  logic signed [MUL_A_W-1:0] tx, ty, tz;
  logic signed [MUL_B_W-1:0] c17, sin17;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [COORD_W-1:0] ctr_sel;
  logic signed [SUM_W-1:0]   rot_sum;
  logic signed [COORD_W-1:0] rot_val;
  logic [ACC_W-1:0]          acc_mag;
  logic [SCREEN_W-1:0]       q_signed;
  logic                      z_behind;
  logic                      last_vertex;
  logic                      accept;

  div_req_t div_req;
  div_rsp_t div_rsp;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (ANGLE_FRAC_BITS - 1);
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  assign accept      = start && !busy;
  assign busy        = (state_r != ST_IDLE);
  assign last_vertex = (idx_r == VIDX_W'(NUM_VERTICES - 1));

  assign vx_rd = vx_mem[idx_r];
  assign vy_rd = vy_mem[idx_r];
  assign vz_rd = vz_mem[idx_r];

  // Offsets from the centre, exact in one extra bit
  assign tx = {vx_rd[COORD_W-1], vx_rd} - {cx_r[COORD_W-1], cx_r};
  assign ty = {vy_rd[COORD_W-1], vy_rd} - {cy_r[COORD_W-1], cy_r};
  assign tz = {vz_rd[COORD_W-1], vz_rd} - {cz_r[COORD_W-1], cz_r};

  assign c17   = {cos_r[TRIG_W-1], cos_r};
  assign sin17 = {sin_r[TRIG_W-1], sin_r};

  assign z_behind = vz_rd[COORD_W-1] || (vz_rd == '0);

  // Shared multiplier
  assign prod     = mul_a * mul_b;
  assign prod_ext = {prod[PROD_W-1], prod};

  // Round half up, put the centre back, clamp to the coordinate range
  always_comb begin
    case (axis_r)
      AXIS_Z:  ctr_sel = (state_r == ST_R1W) ? cx_r : cy_r;
      AXIS_Y:  ctr_sel = (state_r == ST_R1W) ? cz_r : cx_r;
      AXIS_X:  ctr_sel = (state_r == ST_R1W) ? cy_r : cz_r;
      default: ctr_sel = cx_r;
    endcase
    rot_sum = {acc_r[ACC_W-1], acc_r[ACC_W-1:ANGLE_FRAC_BITS]} +
              SUM_W'(ctr_sel);
    if (rot_sum[SUM_W-1:COORD_W-1] == '0 || rot_sum[SUM_W-1:COORD_W-1] == '1) begin
      rot_val = rot_sum[COORD_W-1:0];
    end else if (rot_sum[SUM_W-1]) begin
      rot_val = COORD_MIN;
    end else begin
      rot_val = COORD_MAX;
    end
  end

  assign acc_mag  = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : acc_r;
  assign q_signed = neg_r ? (SCREEN_W'(0) - div_rsp.quot) : div_rsp.quot;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_req_type == REQ_ROTATE) state_nxt = ST_FETCH;
      end
      ST_FETCH: state_nxt = (axis_r == AXIS_NONE) ? ST_ZCHK : ST_R1A;
      ST_R1A:   state_nxt = ST_R1B;
      ST_R1B:   state_nxt = ST_R1W;
      ST_R1W:   state_nxt = ST_R2A;
      ST_R2A:   state_nxt = ST_R2B;
      ST_R2B:   state_nxt = ST_R2W;
      ST_R2W:   state_nxt = ST_ZCHK;
      ST_ZCHK:  state_nxt = z_behind ? ST_EMIT : ST_PA;
      ST_PA:    state_nxt = ST_PB;
      ST_PB:    state_nxt = ST_PS;
      ST_PS:    state_nxt = ST_PW;
      ST_PW: begin
        if (div_rsp.done) state_nxt = sel_y_r ? ST_EMIT : ST_PA;
      end
      ST_EMIT:  state_nxt = last_vertex ? ST_IDLE : ST_FETCH;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath steering per state
  always_comb begin
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = acc_mag[DIV_N_W-1:0];
    div_req.divisor  = vz_rd[DIV_D_W-1:0];
    case (state_r)
      ST_R1A: begin
        mul_a = ta_r;
        mul_b = c17;
      end
      ST_R1B: begin
        mul_a = tb_r;
        mul_b = ns_r;
      end
      ST_R2A: begin
        mul_a = ta_r;
        mul_b = s_r;
      end
      ST_R2B: begin
        mul_a = tb_r;
        mul_b = c17;
      end
      ST_PA: begin
        mul_a = sel_y_r ? {vy_rd[COORD_W-1], vy_rd} : {vx_rd[COORD_W-1], vx_rd};
        mul_b = MUL_B_W'(vd_r);
      end
      ST_PB: begin
        mul_a = {vz_rd[COORD_W-1], vz_rd};
        mul_b = MUL_B_W'(sel_y_r ? hh_r : hw_r);
      end
      ST_PS: div_req.start = 1'b1;
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r <= COS_RST;
      sin_r <= SIN_RST;
      cx_r  <= CX_RST;
      cy_r  <= CY_RST;
      cz_r  <= CZ_RST;
      vd_r  <= VIEW_RST;
      hw_r  <= HW_RST;
      hh_r  <= HH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COS:         cos_r <= cfg_wdata[TRIG_W-1:0];
        REG_SIN:         sin_r <= cfg_wdata[TRIG_W-1:0];
        REG_CENTRE_X:    cx_r  <= cfg_wdata[COORD_W-1:0];
        REG_CENTRE_Y:    cy_r  <= cfg_wdata[COORD_W-1:0];
        REG_CENTRE_Z:    cz_r  <= cfg_wdata[COORD_W-1:0];
        REG_VIEW:        vd_r  <= cfg_wdata[VIEW_W-1:0];
        REG_HALF_WIDTH:  hw_r  <= cfg_wdata[HALF_W-1:0];
        REG_HALF_HEIGHT: hh_r  <= cfg_wdata[HALF_W-1:0];
        default:         cos_r <= cos_r;
      endcase
    end
  end

  // Vertex store: load beats and rotated write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VERTICES; i++) begin
        vx_mem[i] <= '0;
        vy_mem[i] <= '0;
        vz_mem[i] <= '0;
      end
    end else if (accept && in_req_type == REQ_LOAD) begin
      if (int'(in_vertex_sel) < NUM_VERTICES) begin
        vx_mem[in_vertex_sel] <= in_coord_x;
        vy_mem[in_vertex_sel] <= in_coord_y;
        vz_mem[in_vertex_sel] <= in_coord_z;
      end
    end else if (state_r == ST_R1W) begin
      case (axis_r)
        AXIS_Z:  vx_mem[idx_r] <= rot_val;
        AXIS_Y:  vz_mem[idx_r] <= rot_val;
        AXIS_X:  vy_mem[idx_r] <= rot_val;
        default: vx_mem[idx_r] <= vx_rd;
      endcase
    end else if (state_r == ST_R2W) begin
      case (axis_r)
        AXIS_Z:  vy_mem[idx_r] <= rot_val;
        AXIS_Y:  vx_mem[idx_r] <= rot_val;
        AXIS_X:  vz_mem[idx_r] <= rot_val;
        default: vx_mem[idx_r] <= vx_rd;
      endcase
    end
  end

  // Sequencer-owned control: vertex counter and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_EMIT);
      if (accept) begin
        idx_r <= '0;
      end else if (state_r == ST_EMIT) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      axis_r <= in_axis;
      s_r    <= in_direction ? MUL_B_W'(-sin17) : sin17;
      ns_r   <= in_direction ? sin17 : MUL_B_W'(-sin17);
    end
    case (state_r)
      ST_FETCH: begin
        // Hold the original offsets: the first write-back changes the store
        case (axis_r)
          AXIS_Z: begin
            ta_r <= tx;
            tb_r <= ty;
          end
          AXIS_Y: begin
            ta_r <= tz;
            tb_r <= tx;
          end
          default: begin
            ta_r <= ty;
            tb_r <= tz;
          end
        endcase
      end
      ST_R1A, ST_R2A: acc_r <= prod_ext + ROUND_HALF;
      ST_R1B, ST_R2B, ST_PB: acc_r <= acc_r + prod_ext;
      ST_PA: acc_r <= prod_ext;
      ST_ZCHK: begin
        behind_r <= z_behind;
        sel_y_r  <= 1'b0;
        if (z_behind) begin
          sx_r <= '0;
          sy_r <= '0;
        end
      end
      ST_PS: neg_r <= acc_r[ACC_W-1];
      ST_PW: begin
        if (div_rsp.done) begin
          if (sel_y_r) begin
            sy_r <= q_signed;
          end else begin
            sx_r    <= q_signed;
            sel_y_r <= 1'b1;
          end
        end
      end
      ST_EMIT: begin
        out_idx_r    <= idx_r;
        out_sx_r     <= sx_r;
        out_sy_r     <= sy_r;
        out_behind_r <= behind_r;
        out_last_r   <= last_vertex;
      end
      default: begin
        neg_r <= neg_r;
      end
    endcase
  end

  vrp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  assign out_valid       = out_valid_r;
  assign out_point_index = out_idx_r;
  assign out_screen_x    = out_sx_r;
  assign out_screen_y    = out_sy_r;
  assign out_behind_view = out_behind_r;
  assign out_last_point  = out_last_r;

endmodule
